// ===== src/mi3_pkg.sv =====
// Shared constants, tables and types for the 3x3 matrix inverse.
package mi3_pkg;

  localparam int FIELD_W        = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ELEM_WIDTH_DEF = 32;
  localparam int NUM_ELEM       = 9;

  // Operand positions (row-major) of each adjugate entry: a*b - c*d
  localparam int COF_IDX [NUM_ELEM][4] = '{
    '{4, 8, 5, 7},
    '{2, 7, 1, 8},
    '{1, 5, 2, 4},
    '{5, 6, 3, 8},
    '{0, 8, 2, 6},
    '{2, 3, 0, 5},
    '{3, 7, 4, 6},
    '{1, 6, 0, 7},
    '{0, 4, 1, 3}
  };

  // One divider lane's finished element
  typedef struct packed {
    logic [FIELD_W-1:0] val;
    logic               sat;
    logic               dz;
  } lane_res_t;

endpackage

// ===== src/mi3_in_if.sv =====
// Input channel: one 3x3 matrix per beat.
interface mi3_in_if import mi3_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

// ===== src/mi3_out_if.sv =====
// Result channel: one inverse matrix and its flags per beat.
interface mi3_out_if import mi3_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic                      singular;
  logic                      saturated;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  singular, saturated, input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  singular, saturated, output ready);
endinterface

// ===== src/mi3_cof.sv =====
// Cofactor lane: a*b - c*d, exact, two pipeline stages.
module mi3_cof import mi3_pkg::*; #(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [ELEM_WIDTH-1:0] a,
  input  logic signed [ELEM_WIDTH-1:0] b,
  input  logic signed [ELEM_WIDTH-1:0] c,
  input  logic signed [ELEM_WIDTH-1:0] d,
  output logic signed [2*ELEM_WIDTH:0] cof
);
  localparam int PW = 2 * ELEM_WIDTH;

  logic signed [PW-1:0] pa_r, pb_r;
  logic signed [PW:0]   cof_r, cof_nxt;

  assign cof_nxt = (PW+1)'(pa_r) - (PW+1)'(pb_r);

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= a * b;
      pb_r  <= c * d;
      cof_r <= cof_nxt;
    end
  end

  assign cof = cof_r;
endmodule

// ===== src/mi3_det.sv =====
// Determinant merge: first-row elements times cofactors, summed over three stages.
module mi3_det import mi3_pkg::*; #(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [ELEM_WIDTH-1:0]  elem [3],
  input  logic signed [2*ELEM_WIDTH:0]  cof  [3],
  output logic signed [3*ELEM_WIDTH+1:0] det
);
  localparam int EW = ELEM_WIDTH;
  localparam int PW = 2 * EW + 1;
  localparam int DW = 3 * EW + 2;

  logic signed [PW-1:0] plo_r [3];
  logic signed [PW-1:0] phi_r [3];
  logic signed [DW-1:0] term_r [3];
  logic signed [DW-1:0] det_r, det_nxt;

  assign det_nxt = term_r[0] + term_r[1] + term_r[2];

  // Split each cofactor into a signed high half and an unsigned low half
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        plo_r[j]  <= elem[j] * $signed({1'b0, cof[j][EW-1:0]});
        phi_r[j]  <= elem[j] * $signed(cof[j][2*EW:EW]);
        term_r[j] <= (DW'(phi_r[j]) <<< EW) + DW'(plo_r[j]);
      end
      det_r <= det_nxt;
    end
  end

  assign det = det_r;
endmodule

// ===== src/mi3_div.sv =====
// Divider lane: rounded, saturated cofactor * 2^(2F) / det, one quotient bit per stage.
module mi3_div import mi3_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [2*ELEM_WIDTH:0]   cof,
  input  logic signed [3*ELEM_WIDTH+1:0] det,
  output lane_res_t                      res
);
  localparam int EW  = ELEM_WIDTH;
  localparam int CW  = 2 * EW + 1;
  localparam int DW  = 3 * EW + 2;
  localparam int QB  = EW + 2;
  localparam int TW  = 2 * EW + 2 * FRAC_BITS + 2;
  localparam int WW  = (TW > DW + QB) ? TW : DW + QB;
  localparam logic [QB-1:0] LIM_NEG = QB'(1) << (EW - 1);
  localparam logic [QB-1:0] LIM_POS = LIM_NEG - QB'(1);

  logic [CW-1:0] cmag;
  logic [DW-1:0] dmag;
  logic [WW-1:0] t_nxt;
  logic          ovf_nxt;

  logic [WW-1:0] rem_r [QB];
  logic [DW-1:0] dv_r  [QB];
  logic [QB-1:0] q_r   [QB+1];
  logic          neg_r [QB+1];
  logic          ovf_r [QB+1];
  logic          dz_r  [QB+1];

  assign cmag    = cof[CW-1] ? CW'(-cof) : CW'(cof);
  assign dmag    = det[DW-1] ? DW'(-det) : DW'(det);
  // Twice the numerator: one extra quotient bit decides rounding
  assign t_nxt   = WW'(cmag) << (2 * FRAC_BITS + 1);
  assign ovf_nxt = t_nxt >= (WW'(dmag) << QB);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= t_nxt;
      dv_r[0]  <= dmag;
      q_r[0]   <= '0;
      neg_r[0] <= cof[CW-1] ^ det[DW-1];
      ovf_r[0] <= ovf_nxt;
      dz_r[0]  <= (dmag == '0);
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [WW-1:0] dsh;
    logic          ge;

    assign dsh = WW'(dv_r[k-1]) << (QB - k);
    assign ge  = rem_r[k-1] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]   <= {q_r[k-1][QB-2:0], ge};
        neg_r[k] <= neg_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
        dz_r[k]  <= dz_r[k-1];
      end
    end

    if (k < QB) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? rem_r[k-1] - dsh : rem_r[k-1];
          dv_r[k]  <= dv_r[k-1];
        end
      end
    end
  end

  logic [QB:0]    t_inc;
  logic [QB-1:0]  qr, lim, mag;
  logic [EW-1:0]  sval;
  lane_res_t      res_r, res_nxt;

  always_comb begin
    t_inc       = (QB+1)'(q_r[QB]) + (QB+1)'(1);
    qr          = t_inc[QB:1];
    lim         = neg_r[QB] ? LIM_NEG : LIM_POS;
    res_nxt.sat = ovf_r[QB] || (qr > lim);
    mag         = res_nxt.sat ? lim : qr;
    sval        = neg_r[QB] ? EW'(-mag) : mag[EW-1:0];
    res_nxt.val = FIELD_W'(sval);
    res_nxt.dz  = dz_r[QB];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;
endmodule

// ===== src/matrix3_inverse.sv =====
// Top level: 3x3 fixed-point matrix inverse via adjugate over determinant.
//
// in_bus carries one row-major matrix (m00..m22, signed, low ELEM_WIDTH bits
// used, FRAC_BITS fraction bits) per beat; out_bus returns the inverse
// (r00..r22, low ELEM_WIDTH bits significant, upper bits zero) with the
// singular and saturated flags. Both use valid/ready.
// The pipeline runs through the cofactor lanes, the determinant merge and the
// divider lanes (one quotient bit per stage) into the output register.
// Throughput is one matrix per cycle while out_bus does not stall; nine
// divider lanes run side by side. A zero determinant returns the identity
// (clamped when 1.0 does not fit, which sets saturated) and sets singular.
// Reset empties the pipeline; results in flight are dropped.
// When out_bus stalls, the whole pipeline holds, and in_ready drops only
// while a result waits at the output with out_ready low.
module matrix3_inverse import mi3_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mi3_in_if.sink    in_bus,
  mi3_out_if.source out_bus
);
  localparam int EW  = ELEM_WIDTH;
  localparam int CW  = 2 * EW + 1;
  localparam int DW  = 3 * EW + 2;
  localparam int LAT = EW + 10;
  localparam longint ONE_L  = longint'(1) << FRAC_BITS;
  localparam longint LIMP_L = (longint'(1) << (EW - 1)) - longint'(1);
  localparam bit ID_SAT = ONE_L > LIMP_L;
  localparam logic [FIELD_W-1:0] ID_VAL = FIELD_W'(ID_SAT ? LIMP_L : ONE_L);

  logic                 en;
  logic [LAT-1:0]       vld_r;
  logic signed [EW-1:0] mv [NUM_ELEM];
  logic signed [CW-1:0] cof [NUM_ELEM];
  logic signed [CW-1:0] cd1_r [NUM_ELEM];
  logic signed [CW-1:0] cd2_r [NUM_ELEM];
  logic signed [CW-1:0] cd3_r [NUM_ELEM];
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic signed [CW-1:0] det_cof [3];
  logic signed [DW-1:0] det;
  lane_res_t            lane [NUM_ELEM];

  logic [FIELD_W-1:0]   res_r [NUM_ELEM];
  logic [FIELD_W-1:0]   res_nxt [NUM_ELEM];
  logic                 sing_r, sing_nxt, sat_r, sat_nxt;

  // Advance whenever the output register is free or being drained
  assign en           = !vld_r[LAT-1] || out_bus.ready;
  assign in_bus.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_bus.valid};
    end
  end

  assign mv[0] = in_bus.m00[EW-1:0];
  assign mv[1] = in_bus.m01[EW-1:0];
  assign mv[2] = in_bus.m02[EW-1:0];
  assign mv[3] = in_bus.m10[EW-1:0];
  assign mv[4] = in_bus.m11[EW-1:0];
  assign mv[5] = in_bus.m12[EW-1:0];
  assign mv[6] = in_bus.m20[EW-1:0];
  assign mv[7] = in_bus.m21[EW-1:0];
  assign mv[8] = in_bus.m22[EW-1:0];

  for (genvar i = 0; i < NUM_ELEM; i++) begin : g_cof
    mi3_cof #(.ELEM_WIDTH(ELEM_WIDTH)) u_cof (
      .clk (clk),
      .en  (en),
      .a   (mv[COF_IDX[i][0]]),
      .b   (mv[COF_IDX[i][1]]),
      .c   (mv[COF_IDX[i][2]]),
      .d   (mv[COF_IDX[i][3]]),
      .cof (cof[i])
    );
  end

  // Align first-row elements with cofactors, and cofactors with the determinant
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        e1_r[j] <= mv[j];
        e2_r[j] <= e1_r[j];
      end
      for (int i = 0; i < NUM_ELEM; i++) begin
        cd1_r[i] <= cof[i];
        cd2_r[i] <= cd1_r[i];
        cd3_r[i] <= cd2_r[i];
      end
    end
  end

  assign det_cof[0] = cof[0];
  assign det_cof[1] = cof[3];
  assign det_cof[2] = cof[6];

  mi3_det #(.ELEM_WIDTH(ELEM_WIDTH)) u_det (
    .clk  (clk),
    .en   (en),
    .elem (e2_r),
    .cof  (det_cof),
    .det  (det)
  );

  for (genvar i = 0; i < NUM_ELEM; i++) begin : g_div
    mi3_div #(.FRAC_BITS(FRAC_BITS), .ELEM_WIDTH(ELEM_WIDTH)) u_div (
      .clk (clk),
      .en  (en),
      .cof (cd3_r[i]),
      .det (det),
      .res (lane[i])
    );
  end

  // Merge lanes: identity (clamped if 1.0 does not fit) on a zero determinant, else the quotients
  always_comb begin
    sing_nxt = lane[0].dz;
    sat_nxt  = 1'b0;
    for (int i = 0; i < NUM_ELEM; i++) begin
      sat_nxt    = sat_nxt | lane[i].sat;
      res_nxt[i] = lane[i].val;
      if (sing_nxt) begin
        res_nxt[i] = (i % 4 == 0) ? ID_VAL : '0;
      end
    end
    if (sing_nxt) begin
      sat_nxt = ID_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      sing_r <= sing_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign out_bus.valid     = vld_r[LAT-1];
  assign out_bus.r00       = res_r[0];
  assign out_bus.r01       = res_r[1];
  assign out_bus.r02       = res_r[2];
  assign out_bus.r10       = res_r[3];
  assign out_bus.r11       = res_r[4];
  assign out_bus.r12       = res_r[5];
  assign out_bus.r20       = res_r[6];
  assign out_bus.r21       = res_r[7];
  assign out_bus.r22       = res_r[8];
  assign out_bus.singular  = sing_r;
  assign out_bus.saturated = sat_r;

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_bus.valid |-> in_bus.ready)
    else $error("input blocked with no result waiting");

  a_sing_offdiag: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.singular |->
      out_bus.r01 == '0 && out_bus.r12 == '0 && out_bus.r20 == '0)
    else $error("singular result is not the identity");

  a_sing_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.singular |-> out_bus.saturated == ID_SAT)
    else $error("singular result carries wrong saturation flag");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_bus.valid)
    else $error("result valid right after reset");
endmodule

// ===== verif/matrix3_inverse_tb.sv =====
// Testbench for matrix3_inverse: directed table plus random matrices, checked against table values or a predictor.
`timescale 1ns / 1ps

module matrix3_inverse_tb;
  import mi3_pkg::*;

  typedef logic signed [FIELD_W-1:0] mat_t [NUM_ELEM];

  typedef struct {
    logic [FIELD_W-1:0] r [NUM_ELEM];
    bit                 sing;
    bit                 sat;
  } inv_t;

  typedef struct {
    mat_t m;
    bit   typed;
    inv_t want;
  } stim_t;

  localparam int RANDOM_ITEMS = 450;
  localparam int QUIET_TAIL   = 60;
  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [FIELD_W-1:0] ONE_Q = 32'h0001_0000;
  localparam logic [FIELD_W-1:0] MAX_Q = 32'h7fff_ffff;
  localparam logic [FIELD_W-1:0] MIN_Q = 32'h8000_0000;

  logic clk;
  logic rst_n;

  mi3_in_if  in_bus ();
  mi3_out_if out_bus ();

  matrix3_inverse dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus.sink),
    .out_bus(out_bus.source)
  );

  stim_t stim_q[$];
  stim_t driven_q[$];
  inv_t  inverse_q[$];
  int    took_cnt;
  int    got_cnt;
  int    fail_cnt;
  int    idle_cnt;
  bit    quiet;

  // Exact cofactors and determinant, rounded and clamped quotients.
  function automatic inv_t predict_inverse(mat_t e);
    logic signed [127:0] cof [NUM_ELEM];
    logic signed [127:0] det, a, b, c, d;
    logic [127:0] num, den, q, rem, lim;
    bit   neg;
    inv_t res;
    for (int k = 0; k < NUM_ELEM; k++) begin
      a = e[COF_IDX[k][0]];
      b = e[COF_IDX[k][1]];
      c = e[COF_IDX[k][2]];
      d = e[COF_IDX[k][3]];
      cof[k] = a * b - c * d;
    end
    a = e[0];
    b = e[1];
    c = e[2];
    det = a * cof[0] + b * cof[3] + c * cof[6];
    res.sat  = 0;
    res.sing = (det == 0);
    for (int k = 0; k < NUM_ELEM; k++) begin
      if (res.sing) begin
        res.r[k] = (k % 4 == 0) ? ONE_Q : '0;
      end else begin
        neg = cof[k][127] ^ det[127];
        num = cof[k][127] ? -cof[k] : cof[k];
        num = num << (2 * FRAC_BITS_DEF);
        den = det[127] ? -det : det;
        q   = num / den;
        rem = num % den;
        if ((rem << 1) >= den) q = q + 1;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > lim) begin
          res.sat = 1;
          q = lim;
        end
        res.r[k] = neg ? -q[FIELD_W-1:0] : q[FIELD_W-1:0];
      end
    end
    return res;
  endfunction

  function automatic inv_t make_inv(logic [FIELD_W-1:0] dg, logic [FIELD_W-1:0] off,
                                    bit sing, bit sat);
    inv_t res;
    for (int k = 0; k < NUM_ELEM; k++) res.r[k] = (k % 4 == 0) ? dg : off;
    res.sing = sing;
    res.sat  = sat;
    return res;
  endfunction

  function automatic mat_t diag_mat(logic [FIELD_W-1:0] dg, logic [FIELD_W-1:0] off);
    mat_t m;
    for (int k = 0; k < NUM_ELEM; k++) m[k] = (k % 4 == 0) ? dg : off;
    return m;
  endfunction

  task automatic add_row(mat_t m, bit typed, inv_t want);
    stim_t s;
    s.m     = m;
    s.typed = typed;
    s.want  = want;
    stim_q.push_back(s);
  endtask

  task automatic build_stimulus();
    mat_t m;
    inv_t none;
    int   kind;
    none = make_inv('0, '0, 0, 0);
    // identity, zero, rank one, doubled identity, tiny diagonals that clamp
    add_row(diag_mat(ONE_Q, '0), 1, make_inv(ONE_Q, '0, 0, 0));
    add_row(diag_mat('0, '0), 1, make_inv(ONE_Q, '0, 1, 0));
    add_row(diag_mat(ONE_Q, ONE_Q), 1, make_inv(ONE_Q, '0, 1, 0));
    add_row(diag_mat(MAX_Q, MAX_Q), 1, make_inv(ONE_Q, '0, 1, 0));
    add_row(diag_mat(MIN_Q, MIN_Q), 1, make_inv(ONE_Q, '0, 1, 0));
    add_row(diag_mat(32'h0002_0000, '0), 1, make_inv(32'h0000_8000, '0, 0, 0));
    add_row(diag_mat(32'h0000_0001, '0), 1, make_inv(MAX_Q, '0, 0, 1));
    add_row(diag_mat(32'hffff_ffff, '0), 1, make_inv(MIN_Q, '0, 0, 1));
    add_row(diag_mat(MAX_Q, '0), 0, none);
    add_row(diag_mat(MIN_Q, '0), 0, none);
    add_row(diag_mat(MAX_Q, MIN_Q), 0, none);
    add_row(diag_mat(MIN_Q, MAX_Q), 0, none);
    add_row(diag_mat(32'hffff_0000, '0), 0, none);
    add_row(diag_mat(32'h0003_0000, 32'h0001_0000), 0, none);
    add_row(diag_mat(32'h0000_0003, 32'h0000_0001), 0, none);
    m = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
          32'h0000_0000, 32'h0001_0000, 32'h0004_0000,
          32'h0005_0000, 32'h0006_0000, 32'h0000_0000};
    add_row(m, 0, none);
    m = '{32'h0000_0000, 32'h0001_0000, 32'h0000_0000,
          32'h0000_0000, 32'h0000_0000, 32'h0001_0000,
          32'h0001_0000, 32'h0000_0000, 32'h0000_0000};
    add_row(m, 0, none);
    // row two equal to row zero: singular with nonzero elements
    m = '{32'h0001_8000, 32'hfffe_0000, 32'h0000_4000,
          32'h0003_0000, 32'h0001_0000, 32'hffff_0000,
          32'h0001_8000, 32'hfffe_0000, 32'h0000_4000};
    add_row(m, 0, none);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      kind = $urandom_range(0, 9);
      for (int k = 0; k < NUM_ELEM; k++) begin
        case (kind)
          0, 1, 2: begin
            m[k] = $urandom;
          end
          3, 4, 5, 6: begin
            m[k] = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
          end
          7: begin
            m[k] = ((k % 4 == 0) ? ONE_Q : '0) + ($urandom_range(0, 255) - 128);
          end
          default: begin
            m[k] = $signed($urandom_range(0, 32'h0000_0400)) - 32'sh0000_0200;
          end
        endcase
      end
      // force some singular matrices: copy a row or clear one
      if (kind == 8) begin
        for (int k = 0; k < 3; k++) m[6 + k] = m[k];
      end else if (kind == 9 && $urandom_range(0, 1)) begin
        for (int k = 0; k < 3; k++) m[3 + k] = '0;
      end
      add_row(m, 0, none);
    end
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n <= 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
  end

  // Sender: hold the beat until accepted, then advance or idle a burst.
  initial begin
    int    gap;
    stim_t s;
    gap = 0;
    in_bus.valid <= 0;
    in_bus.m00 <= '0; in_bus.m01 <= '0; in_bus.m02 <= '0;
    in_bus.m10 <= '0; in_bus.m11 <= '0; in_bus.m12 <= '0;
    in_bus.m20 <= '0; in_bus.m21 <= '0; in_bus.m22 <= '0;
    build_stimulus();
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!in_bus.valid || in_bus.ready) begin
        if (gap == 0 && !quiet && stim_q.size() != 0 && $urandom_range(0, 4) == 0)
          gap = $urandom_range(1, 8);
        if (gap > 0 || stim_q.size() == 0) begin
          if (gap > 0) gap--;
          in_bus.valid <= 0;
        end else begin
          s = stim_q.pop_front();
          driven_q.push_back(s);
          in_bus.m00 <= s.m[0]; in_bus.m01 <= s.m[1]; in_bus.m02 <= s.m[2];
          in_bus.m10 <= s.m[3]; in_bus.m11 <= s.m[4]; in_bus.m12 <= s.m[5];
          in_bus.m20 <= s.m[6]; in_bus.m21 <= s.m[7]; in_bus.m22 <= s.m[8];
          in_bus.valid <= 1;
        end
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off, none in the tail.
  initial begin
    int  hold;
    bit  held;
    hold = 0;
    held = 0;
    out_bus.ready <= 0;
    forever begin
      @(posedge clk);
      if (!held && got_cnt >= 40) begin
        held = 1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_bus.ready <= 0;
      end else if (quiet) begin
        out_bus.ready <= 1;
      end else begin
        if ($urandom_range(0, 4) == 0) hold = $urandom_range(1, 8);
        out_bus.ready <= (hold == 0);
      end
    end
  end

  // Monitor: predict (or take the table value) on each accepted input beat, compare each output beat.
  always @(posedge clk) begin
    stim_t s;
    mat_t  m;
    inv_t  got, want;
    string fname;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        s = driven_q.pop_front();
        m = '{in_bus.m00, in_bus.m01, in_bus.m02, in_bus.m10, in_bus.m11,
              in_bus.m12, in_bus.m20, in_bus.m21, in_bus.m22};
        inverse_q.push_back(s.typed ? s.want : predict_inverse(m));
        took_cnt++;
        if (took_cnt >= RANDOM_ITEMS - QUIET_TAIL) quiet <= 1;
      end
      if (out_bus.valid && out_bus.ready) begin
        got.r = '{out_bus.r00, out_bus.r01, out_bus.r02, out_bus.r10, out_bus.r11,
                  out_bus.r12, out_bus.r20, out_bus.r21, out_bus.r22};
        got.sing = out_bus.singular;
        got.sat  = out_bus.saturated;
        got_cnt++;
        if (inverse_q.size() == 0) begin
          $error("result beat with no expected inverse waiting");
          fail_cnt++;
        end else begin
          want = inverse_q.pop_front();
          for (int k = 0; k < NUM_ELEM; k++) begin
            if (got.r[k] !== want.r[k]) begin
              fname = $sformatf("r%0d%0d", k / 3, k % 3);
              $error("%s: expected %h, got %h", fname, want.r[k], got.r[k]);
              fail_cnt++;
            end
          end
          if (got.sing !== want.sing) begin
            $error("singular: expected %0d, got %0d", want.sing, got.sing);
            fail_cnt++;
          end
          if (got.sat !== want.sat) begin
            $error("saturated: expected %0d, got %0d", want.sat, got.sat);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: count cycles with no beat on either side, and fail the run at STALL_LIMIT.
  initial begin
    idle_cnt = 0;
    forever begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cnt = 0;
      else
        idle_cnt++;
      if (idle_cnt >= STALL_LIMIT) begin
        $display("matrix3_inverse verification failed");
        $finish;
      end
    end
  end

  initial begin
    took_cnt = 0;
    got_cnt  = 0;
    fail_cnt = 0;
    quiet    = 0;
    @(posedge clk);
    while (stim_q.size() != 0 || driven_q.size() != 0 || inverse_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && inverse_q.size() == 0) begin
      $display("matrix3_inverse verification clean");
    end else begin
      $display("matrix3_inverse verification failed");
    end
    $finish;
  end

endmodule
